// File: src/lpib_pkg.sv
// ----------------------------------------------------------------------------
// lpib_pkg: shared constants, types and functions
// Fixed point helpers and controller/datapath interface types for the lift
// polynomial inverse search.
// ----------------------------------------------------------------------------
package lpib_pkg;

    localparam int POLY_DEGREE = 4;
    localparam int ITER_LIMIT  = 256;

    localparam int NUM_COEFF = POLY_DEGREE + 1;
    localparam int TERM_W    = $clog2(NUM_COEFF);
    localparam int STEP_W    = $clog2(ITER_LIMIT + 2);

    localparam int DATA_W    = 32;
    localparam int MAXA_W    = 18;
    localparam int TOL_W     = 17;
    localparam int ALPHA_W   = 19;
    localparam int CFG_IDX_W = 3;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ALPHA = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_0   = 3'd2;

    localparam logic [MAXA_W-1:0] MAXA_RESET = 18'd19661;
    localparam logic [TOL_W-1:0]  TOL_RESET  = 17'd66;

    // 1.0 in Q16.16
    localparam logic signed [DATA_W-1:0] ONE_Q = 32'sh0001_0000;

    typedef struct packed {
        logic load;   // start a new search
        logic mid;    // form midpoint, clear term state
        logic mul;    // launch coefficient and power products
        logic acc;    // round products, accumulate
        logic chk;    // move bounds, count step
        logic emit;   // load output register
    } t_dp_cmd;

    typedef struct packed {
        logic last_term;
        logic limit;
        logic conv;
    } t_dp_sts;

    // Q16.16 product: round to nearest (ties up), saturate to 32 bit
    function automatic logic signed [DATA_W-1:0] f_qround(input logic signed [63:0] prod);
        logic signed [63:0] t;
        logic signed [47:0] s;
        begin
            t = prod + 64'sd32768;
            s = t[63:16];
            if (s > $signed(48'h0000_7FFF_FFFF)) begin
                f_qround = 32'sh7FFF_FFFF;
            end else if (s < $signed(48'hFFFF_8000_0000)) begin
                f_qround = 32'sh8000_0000;
            end else begin
                f_qround = s[31:0];
            end
        end
    endfunction

    // saturating 32 bit add
    function automatic logic signed [DATA_W-1:0] f_sat_add(input logic signed [DATA_W-1:0] a,
                                                          input logic signed [DATA_W-1:0] b);
        logic signed [DATA_W:0] s;
        begin
            s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
            if (s[DATA_W] != s[DATA_W-1]) begin
                f_sat_add = s[DATA_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else begin
                f_sat_add = s[DATA_W-1:0];
            end
        end
    endfunction

endpackage

// File: src/lpib_dp.sv
// ----------------------------------------------------------------------------
// lpib_dp: search datapath
// Config registers, bisection bounds, two registered multipliers for the
// polynomial terms, convergence and limit status, output register.
// ----------------------------------------------------------------------------
module lpib_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [lpib_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [lpib_pkg::DATA_W-1:0]            i_cfg_data,
    input  logic signed [lpib_pkg::DATA_W-1:0]     i_target_lift,
    input  lpib_pkg::t_dp_cmd                      i_cmd,
    output lpib_pkg::t_dp_sts                      o_sts,
    output logic signed [lpib_pkg::ALPHA_W-1:0]    o_alpha,
    output logic                                   o_failed
);
    import lpib_pkg::*;

    logic [MAXA_W-1:0]              r_max_alpha;
    logic [TOL_W-1:0]               r_tol;
    logic signed [DATA_W-1:0]       r_coeff [NUM_COEFF];

    logic signed [DATA_W-1:0]       r_target;
    logic signed [DATA_W-1:0]       r_lo;
    logic signed [DATA_W-1:0]       r_hi;
    logic signed [DATA_W-1:0]       r_mid;
    logic signed [DATA_W-1:0]       r_p;
    logic signed [DATA_W-1:0]       r_acc;
    logic signed [63:0]             r_prod_c;
    logic signed [63:0]             r_prod_p;
    logic [TERM_W-1:0]              r_term;
    logic [STEP_W-1:0]              r_step;
    logic                           r_failed;
    logic signed [ALPHA_W-1:0]      r_alpha;
    logic                           r_fail_out;

    logic signed [DATA_W:0]         w_sum;
    logic signed [DATA_W:0]         w_err;
    logic [DATA_W:0]                w_abs;
    logic [CFG_IDX_W-1:0]           w_cidx;

    assign w_sum  = {r_lo[DATA_W-1], r_lo} + {r_hi[DATA_W-1], r_hi};
    assign w_err  = {r_acc[DATA_W-1], r_acc} - {r_target[DATA_W-1], r_target};
    assign w_abs  = w_err[DATA_W] ? (DATA_W+1)'(-w_err) : (DATA_W+1)'(w_err);
    assign w_cidx = i_cfg_index - CFG_COEFF_0;

    assign o_sts.last_term = (r_term == TERM_W'(POLY_DEGREE));
    assign o_sts.limit     = (r_step > STEP_W'(ITER_LIMIT));
    assign o_sts.conv      = (w_abs <= {{(DATA_W+1-TOL_W){1'b0}}, r_tol});

    assign o_alpha  = r_alpha;
    assign o_failed = r_fail_out;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_alpha <= MAXA_RESET;
            r_tol       <= TOL_RESET;
            for (int k = 0; k < NUM_COEFF; k++) begin
                r_coeff[k] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_MAX_ALPHA) begin
                r_max_alpha <= i_cfg_data[MAXA_W-1:0];
            end else if (i_cfg_index == CFG_TOLERANCE) begin
                r_tol <= i_cfg_data[TOL_W-1:0];
            end else if (i_cfg_index >= CFG_COEFF_0 &&
                         w_cidx <= CFG_IDX_W'(POLY_DEGREE)) begin
                r_coeff[w_cidx[TERM_W-1:0]] <= i_cfg_data;
            end
        end
    end

    // search datapath
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_target <= i_target_lift;
            r_lo     <= -$signed({{(DATA_W-MAXA_W){1'b0}}, r_max_alpha});
            r_hi     <= $signed({{(DATA_W-MAXA_W){1'b0}}, r_max_alpha});
            r_step   <= '0;
            r_failed <= 1'b0;
        end
        if (i_cmd.mid) begin
            r_mid  <= w_sum[DATA_W:1];
            r_p    <= ONE_Q;
            r_acc  <= '0;
            r_term <= '0;
        end
        if (i_cmd.mul) begin
            r_prod_c <= r_coeff[r_term] * r_p;
            r_prod_p <= r_p * r_mid;
        end
        if (i_cmd.acc) begin
            r_acc <= f_sat_add(r_acc, f_qround(r_prod_c));
            r_p   <= f_qround(r_prod_p);
            if (!o_sts.last_term) begin
                r_term <= r_term + 1'b1;
            end
        end
        if (i_cmd.chk) begin
            if (r_acc > r_target) begin
                r_hi <= r_mid;
            end else begin
                r_lo <= r_mid;
            end
            if (o_sts.limit) begin
                r_failed <= 1'b1;
            end else begin
                r_step <= r_step + 1'b1;
            end
        end
        if (i_cmd.emit) begin
            r_alpha    <= r_failed ? '0 : r_mid[ALPHA_W-1:0];
            r_fail_out <= r_failed;
        end
    end

endmodule

// File: src/lpib_ctrl.sv
// ----------------------------------------------------------------------------
// lpib_ctrl: search controller
// Sequences midpoint, term products, accumulation and bound update for each
// step; owns the input handshake and the output valid.
// ----------------------------------------------------------------------------
module lpib_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lpib_pkg::t_dp_cmd   o_cmd,
    input  lpib_pkg::t_dp_sts   i_sts
);
    import lpib_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MID,
        S_MUL,
        S_ACC,
        S_CHK,
        S_DONE
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    w_slot_free;

    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MID;
                end
            end
            S_MID: begin
                o_cmd.mid = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_sts.last_term ? S_CHK : S_MUL;
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                n_state   = (i_sts.limit || i_sts.conv) ? S_DONE : S_MID;
            end
            S_DONE: begin
                if (w_slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// File: src/lift_polynomial_inverse_bisection_top.sv
// ----------------------------------------------------------------------------
// lift_polynomial_inverse_bisection_top: angle of attack from target lift
// Bisection search for the angle at which a quartic lift polynomial
// (Q16.16) meets the requested lift coefficient.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel: i_in_valid / o_in_stall carry one target_lift beat.
//    A beat is taken only while no search is running.
//  - Output channel: o_out_valid / i_out_stall carry alpha and failed.
//    alpha is 0 and failed is 1 when the step limit runs out.
//  - Config port: i_cfg_we, i_cfg_index, i_cfg_data. Index 0 max_alpha,
//    1 tolerance, 2..6 coeff_0..coeff_4. Write only while idle.
//  - Each bisection step runs midpoint, five terms with a multiply state
//    and an accumulate state each on the product pair (coefficient lane
//    and power lane), bound update. A search runs 1 to 258 steps.
//    The serial power chain mid^k in the polynomial sets the step length.
//  - The result sits in an output register; the next beat is accepted as
//    soon as it is loaded, even while the receiver stalls. A finished
//    search holds until that register is free.
//  - Synchronous active-low reset: idle, output empty, config to defaults
//    (max_alpha 0.3, tolerance 0.001, coefficients 0).
// ----------------------------------------------------------------------------
module lift_polynomial_inverse_bisection_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [lpib_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [lpib_pkg::DATA_W-1:0]            i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [lpib_pkg::DATA_W-1:0]     i_target_lift,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [lpib_pkg::ALPHA_W-1:0]    o_alpha,
    output logic                                   o_failed
);
    import lpib_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    lpib_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    lpib_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_target_lift (i_target_lift),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_alpha       (o_alpha),
        .o_failed      (o_failed)
    );

    // a failed search never reports an angle
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_failed |-> o_alpha == '0)
        else $error("failed result with nonzero alpha");

    // accepting a beat starts a search
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not blocked after accept");

    // a new result only comes out of a running search
    a_result_from_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a search");

endmodule
